/* hdl/ils_pkg.sv */
// Shared constants and types for the indexed list store.
package ils_pkg;

   localparam int DEPTH         = 32;
   localparam int ITEM_W        = 32;
   localparam int FUNC_W        = 3;
   localparam int POS_FIELD_W   = 6;
   localparam int OUT_ITEM_W    = 32;
   localparam int COUNT_FIELD_W = 6;
   localparam int CNT_W         = $clog2(DEPTH + 1);
   // index width wide enough for both the count and the position field
   localparam int POS_W         = (CNT_W > POS_FIELD_W) ? CNT_W : POS_FIELD_W;

   localparam logic [FUNC_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [FUNC_W-1:0] OP_POP    = 3'd1;
   localparam logic [FUNC_W-1:0] OP_INSERT = 3'd2;
   localparam logic [FUNC_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [FUNC_W-1:0] OP_READ   = 3'd4;

   typedef struct packed {
      logic              write;
      logic [FUNC_W-1:0] func;
      logic [POS_W-1:0]  pos;
      logic [POS_W-1:0]  count;
      logic [POS_W-1:0]  rd_pos;
      logic [ITEM_W-1:0] item;
   } ils_cmd_type;

endpackage

/* hdl/ils_cell.sv */
// One storage cell of the list: holds one entry and shifts with its neighbours.
module ils_cell import ils_pkg::*; (
   input  logic              clock,
   input  ils_cmd_type       cmd,
   input  logic [POS_W-1:0]  cell_index,
   input  logic [ITEM_W-1:0] prev_value,
   input  logic [ITEM_W-1:0] next_value,
   output logic [ITEM_W-1:0] value,
   output logic [ITEM_W-1:0] rd_value
);

   logic [ITEM_W-1:0] value_ff;
   logic [ITEM_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (cmd.write) begin
         unique case (cmd.func)
            OP_PUSH: begin
               if (cell_index == cmd.count) value_in = cmd.item;
            end
            OP_INSERT: begin
               if (cell_index == cmd.pos) begin
                  value_in = cmd.item;
               end else if (cell_index > cmd.pos && cell_index <= cmd.count) begin
                  value_in = prev_value;
               end
            end
            OP_REMOVE: begin
               if (cell_index >= cmd.pos && (cell_index + 1'b1) < cmd.count) begin
                  value_in = next_value;
               end
            end
            default: value_in = value_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign rd_value = (cell_index == cmd.rd_pos) ? value_ff : '0;

endmodule

/* hdl/indexed_list_store.sv */
// Top level of the indexed list store: request decode, cell row and result register.
// An ordered store of up to DEPTH words held in a row of cells, one entry per cell.
// Each request (push, pop, insert at, remove at, read at) is done in the cycle it is accepted: all
// cells shift together and the word read or taken out is picked from the row, and the
// result lands in a single output register in the cycle after acceptance. A new request is
// taken in every cycle in which the result register is empty or being emptied, so the
// sustained rate is one item per clock. Only the count and the result valid flag are reset; entries need no clearing.
module indexed_list_store import ils_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // position[5:0], item_value[37:6], zero pad
   input  logic [2:0]  req_tuser,  // func[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // item_out[31:0], entry_count[37:32], zero pad
   output logic        rsp_tuser   // ok
);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff;
   logic [OUT_ITEM_W-1:0]    rsp_item_ff;
   logic [COUNT_FIELD_W-1:0] rsp_count_ff;

   logic                     accept;
   logic                     ok_c;
   logic [POS_W-1:0]         pos_c, cnt_c;
   logic [ITEM_W-1:0]        rd_word;
   ils_cmd_type              cmd;

   logic [ITEM_W-1:0] cell_value [DEPTH];
   logic [ITEM_W-1:0] cell_rd    [DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign pos_c      = POS_W'(req_tdata[POS_FIELD_W-1:0]);
   assign cnt_c      = POS_W'(count_ff);

   always_comb begin
      ok_c = 1'b0;
      unique case (req_tuser)
         OP_PUSH:   ok_c = count_ff < CNT_W'(DEPTH);
         OP_POP:    ok_c = count_ff != '0;
         OP_INSERT: ok_c = (count_ff < CNT_W'(DEPTH)) && (pos_c <= cnt_c);
         OP_REMOVE: ok_c = pos_c < cnt_c;
         OP_READ:   ok_c = pos_c < cnt_c;
         default:   ok_c = 1'b0;
      endcase
   end

   always_comb begin
      cmd.write  = accept && ok_c;
      cmd.func   = req_tuser;
      cmd.pos    = pos_c;
      cmd.count  = cnt_c;
      cmd.rd_pos = (req_tuser == OP_POP) ? cnt_c - 1'b1 : pos_c;
      cmd.item   = req_tdata[POS_FIELD_W +: ITEM_W];
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ITEM_W-1:0] prev_w, next_w;
      if (i == 0) begin : g_first
         assign prev_w = '0;
      end else begin : g_prev
         assign prev_w = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_next
         assign next_w = cell_value[i+1];
      end
      ils_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (POS_W'(i)),
         .prev_value (prev_w),
         .next_value (next_w),
         .value      (cell_value[i]),
         .rd_value   (cell_rd[i])
      );
   end

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_word = rd_word | cell_rd[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.write) begin
         unique case (req_tuser) inside
            OP_PUSH, OP_INSERT: count_in = count_ff + 1'b1;
            OP_POP, OP_REMOVE:  count_in = count_ff - 1'b1;
            default:            count_in = count_ff;
         endcase
      end
      rsp_valid_in = accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ok_ff    <= ok_c;
         rsp_item_ff  <= (ok_c && req_tuser != OP_PUSH && req_tuser != OP_INSERT)
                         ? OUT_ITEM_W'(rd_word) : '0;
         rsp_count_ff <= COUNT_FIELD_W'(POS_W'(count_in));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_item_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[OUT_ITEM_W-1:0] == '0))
      else $error("failed request returned a non-zero word");

   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !ok_c) |=> (count_ff == $past(count_ff)))
      else $error("failed request changed the entry count");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_count_ff == COUNT_FIELD_W'(POS_W'(count_ff))))
      else $error("reported count differs from stored count");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the indexed list store: directed and random request streams.
`timescale 1ns / 100ps

module testbench;
   import ils_pkg::*;

   localparam int                CYCLE_LIMIT = 200000;
   localparam int                RANDOM_ITEMS = 800;
   localparam logic [FUNC_W-1:0] FUNC_MAX = {FUNC_W{1'b1}};

   typedef struct packed {
      logic                     ok;
      logic [OUT_ITEM_W-1:0]    word;
      logic [COUNT_FIELD_W-1:0] count;
   } list_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // position[5:0], item_value[37:6], zero pad
   logic [2:0]  req_tuser = '0;  // func[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // item_out[31:0], entry_count[37:32], zero pad
   logic        rsp_tuser;       // ok

   logic [ITEM_W-1:0] list_words [DEPTH];
   int                list_count = 0;
   list_result_type   pending_results [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   bit                idling_on = 1'b1;
   bit                growing = 1'b1;

   indexed_list_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= idling_on ? ($urandom_range(99) >= 19) : 1'b1;
   end

   // apply one accepted request to the shadow list and queue its result
   function automatic void apply_request(input logic [FUNC_W-1:0] op,
                                         input logic [POS_FIELD_W-1:0] pos,
                                         input logic [ITEM_W-1:0] value);
      list_result_type r;
      int              p;
      p = int'(pos);
      r = '0;
      case (op)
         OP_PUSH: begin
            if (list_count < DEPTH) begin
               list_words[list_count] = value;
               list_count++;
               r.ok = 1'b1;
            end
         end
         OP_POP: begin
            if (list_count > 0) begin
               list_count--;
               r.word = list_words[list_count];
               r.ok = 1'b1;
            end
         end
         OP_INSERT: begin
            if (list_count < DEPTH && p <= list_count) begin
               for (int i = list_count; i > p; i--) list_words[i] = list_words[i-1];
               list_words[p] = value;
               list_count++;
               r.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (p < list_count) begin
               r.word = list_words[p];
               for (int i = p; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
               list_count--;
               r.ok = 1'b1;
            end
         end
         OP_READ: begin
            if (p < list_count) begin
               r.word = list_words[p];
               r.ok = 1'b1;
            end
         end
         default: ;
      endcase
      r.count = list_count[COUNT_FIELD_W-1:0];
      pending_results.push_back(r);
   endfunction

   task automatic send_item(input logic [FUNC_W-1:0] op,
                            input logic [POS_FIELD_W-1:0] pos,
                            input logic [ITEM_W-1:0] value);
      if (idling_on) begin
         while ($urandom_range(99) < 19) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(40 - ITEM_W - POS_FIELD_W){1'b0}}, value, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(op, pos, value);
   endtask

   always @(posedge clock) begin
      list_result_type want;
      list_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok    = rsp_tuser;
         got.word  = rsp_tdata[OUT_ITEM_W-1:0];
         got.count = rsp_tdata[OUT_ITEM_W +: COUNT_FIELD_W];
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: ok %0b item %h count %0d",
                        got.ok, got.word, got.count);
         end else begin
            want = pending_results.pop_front();
            if (got.ok !== want.ok || got.word !== want.word || got.count !== want.count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected ok %0b item %h count %0d,",
                            " got ok %0b item %h count %0d"},
                           want.ok, want.word, want.count, got.ok, got.word, got.count);
            end
         end
      end
   end

   function automatic logic [ITEM_W-1:0] random_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // mostly in-range positions, some noise across the whole field
   function automatic logic [POS_FIELD_W-1:0] pick_position(input logic [FUNC_W-1:0] op);
      if ($urandom_range(99) < 15) return POS_FIELD_W'($urandom_range(63));
      if (op == OP_INSERT) return POS_FIELD_W'($urandom_range(list_count));
      if (list_count == 0) return '0;
      return POS_FIELD_W'($urandom_range(list_count - 1));
   endfunction

   task automatic random_items(input int n);
      logic [FUNC_W-1:0] op;
      int                r;
      for (int k = 0; k < n; k++) begin
         if (list_count == DEPTH) growing = 1'b0;
         else if (list_count == 0) growing = 1'b1;
         else if ($urandom_range(99) < 2) growing = ~growing;
         r = $urandom_range(99);
         if (r < 4) op = FUNC_W'($urandom_range(FUNC_MAX, OP_READ + 1));
         else if (growing) op = (r < 29) ? OP_PUSH : (r < 54) ? OP_INSERT :
                                (r < 64) ? OP_POP : (r < 79) ? OP_REMOVE : OP_READ;
         else op = (r < 14) ? OP_PUSH : (r < 24) ? OP_INSERT :
                   (r < 49) ? OP_POP : (r < 74) ? OP_REMOVE : OP_READ;
         send_item(op, pick_position(op), random_word());
      end
   endtask

   task automatic test_empty_cases();
      send_item(OP_POP, '0, $urandom);
      send_item(OP_READ, '0, $urandom);
      send_item(OP_REMOVE, '0, $urandom);
      send_item(OP_INSERT, 6'd1, $urandom);
      send_item(OP_INSERT, 6'd63, $urandom);
      send_item(OP_INSERT, '0, 32'h0000_0000);
      send_item(OP_PUSH, 6'd63, 32'hFFFF_FFFF);
      send_item(OP_INSERT, 6'd2, 32'hA5A5_5A5A);
      send_item(OP_INSERT, '0, 32'h8000_0001);
      send_item(OP_INSERT, 6'd2, $urandom);
      send_item(OP_READ, '0, $urandom);
      send_item(OP_READ, 6'd4, $urandom);
      send_item(OP_READ, 6'd5, $urandom);
      send_item(OP_READ, 6'd63, $urandom);
      send_item(OP_REMOVE, 6'd2, $urandom);
      send_item(OP_REMOVE, 6'd3, $urandom);
      send_item(OP_REMOVE, 6'd4, $urandom);
      send_item(OP_REMOVE, '0, $urandom);
      for (int f = OP_READ + 1; f <= FUNC_MAX; f++)
         send_item(FUNC_W'(f), 6'd63, 32'hFFFF_FFFF);
      send_item(OP_POP, 6'd63, $urandom);
      send_item(OP_POP, '0, $urandom);
      send_item(OP_POP, '0, $urandom);
   endtask

   task automatic test_fill_to_capacity();
      while (list_count < DEPTH) begin
         if ($urandom_range(1))
            send_item(OP_PUSH, POS_FIELD_W'($urandom_range(63)), random_word());
         else
            send_item(OP_INSERT, POS_FIELD_W'($urandom_range(list_count)), random_word());
      end
      send_item(OP_PUSH, '0, $urandom);
      send_item(OP_INSERT, '0, $urandom);
      send_item(OP_INSERT, POS_FIELD_W'(DEPTH), $urandom);
      send_item(OP_READ, POS_FIELD_W'(DEPTH - 1), $urandom);
      send_item(OP_READ, POS_FIELD_W'(DEPTH), $urandom);
      send_item(OP_REMOVE, POS_FIELD_W'(DEPTH), $urandom);
      send_item(OP_REMOVE, POS_FIELD_W'(DEPTH - 1), $urandom);
      send_item(OP_INSERT, POS_FIELD_W'(DEPTH - 1), 32'hFFFF_FFFF);
      send_item(OP_POP, '0, $urandom);
      while (list_count > 0)
         send_item(OP_REMOVE, POS_FIELD_W'($urandom_range(list_count - 1)), $urandom);
   endtask

   task automatic test_random_traffic();
      random_items(RANDOM_ITEMS);
   endtask

   task automatic test_back_to_back();
      idling_on = 1'b0;
      random_items(300);
      idling_on = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_cases();
      test_fill_to_capacity();
      test_random_traffic();
      test_back_to_back();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
